[rtl/core/gcec_pkg.sv]
// shared types and constants for the greedy constraint edge colouring core
package gcec_pkg;

  localparam int PIDX_W    = 10;
  localparam int COLOUR_W  = 6;
  localparam int COUNT_W   = 7;
  localparam int EPOCH_W   = 8;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;

  // last field in the lowest bits
  typedef struct packed {
    logic              new_frame;
    logic              b_is_static;
    logic [PIDX_W-1:0] particle_b;
    logic              a_is_static;
    logic [PIDX_W-1:0] particle_a;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  colours_used;
    logic                overflow;
    logic [COLOUR_W-1:0] colour;
  } out_item_t;

  typedef struct packed {
    logic                found;
    logic [COLOUR_W-1:0] colour;
    logic [COUNT_W-1:0]  count;
  } gcec_res_t;

endpackage

[rtl/core/greedy_constraint_edge_colouring_core.sv]
// Greedy edge colouring core: takes one particle-pair item per cycle when in_tready is high
// (not while clearing or while the output stalls) and returns one result item per input via
// the s1 stage and the output register. The per-particle colour masks live in two one-write,
// two-read memories of NUM_PARTICLES words, each word tagged with a frame epoch, so new_frame
// empties every mask without touching memory; the previous item's writes are forwarded to the
// next one. After reset the block runs a clearing pass over every word before accepting items,
// and it runs the same pass again when a new_frame item arrives while the epoch is EPOCH_LAST.
module greedy_constraint_edge_colouring_core #(
  parameter int NUM_PARTICLES = 1024,
  parameter int MAX_COLOURS   = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // particle_a[9:0], a_is_static[10], particle_b[20:11], b_is_static[21], new_frame[22]
  input  logic [gcec_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // colour[5:0], overflow[6], colours_used[13:7]
  output logic [gcec_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import gcec_pkg::*;

  localparam int AW    = $clog2(NUM_PARTICLES);
  localparam int MW    = MAX_COLOURS;
  localparam int DW    = EPOCH_W + MW;
  localparam int PW    = $clog2(NUM_PARTICLES + 1);
  localparam int CMP_W = (PW > PIDX_W) ? PW : PIDX_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_PARTICLES - 1);

  in_item_t in_item;
  assign in_item = in_item_t'(in_tdata[$bits(in_item_t)-1:0]);

  logic                in_fire;
  logic                s1_fire;
  logic                wrap_hold;
  logic                clr_start;

  logic                s1_valid_r, s1_valid_nxt;
  in_item_t            s1_item_r;
  logic [EPOCH_W-1:0]  s1_epoch_r;
  logic [EPOCH_W-1:0]  epoch_r, epoch_nxt;
  logic [COUNT_W-1:0]  count_r;
  logic                clr_busy_r, clr_busy_nxt;
  logic [AW-1:0]       clr_addr_r;

  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r;

  logic                fwd_a_en_r, fwd_b_en_r;
  logic [PIDX_W-1:0]   fwd_a_idx_r, fwd_b_idx_r;
  logic [MW-1:0]       fwd_a_mask_r, fwd_b_mask_r;
  logic [EPOCH_W-1:0]  fwd_epoch_r;

  logic [DW-1:0]       ra_pa, ra_pb, rb_pa, rb_pb;
  logic                we_a, we_b;
  logic                wr_a, wr_b;
  logic [AW-1:0]       waddr_a, waddr_b;
  logic [DW-1:0]       wdata_a, wdata_b;

  logic                live_a, live_b;
  logic                fwd_ok;
  logic [MW-1:0]       part_a_pa, part_b_pa, part_a_pb, part_b_pb;
  logic [MW-1:0]       mask_a, mask_b;
  logic [MW-1:0]       new_mask_a, new_mask_b;
  logic [COUNT_W-1:0]  count_base;
  gcec_res_t           res;

  // handshake
  assign wrap_hold  = in_item.new_frame && (epoch_r == EPOCH_LAST);
  assign s1_fire    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !clr_busy_r && !wrap_hold && (!s1_valid_r || s1_fire);
  assign in_fire    = in_tvalid && in_tready;
  assign clr_start  = in_tvalid && wrap_hold && !s1_valid_r && !clr_busy_r;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_comb begin
    epoch_nxt = epoch_r;
    if (clr_busy_r && (clr_addr_r == LAST_ADDR)) begin
      epoch_nxt = EPOCH_FIRST;
    end else if (in_fire && in_item.new_frame) begin
      epoch_nxt = epoch_r + EPOCH_W'(1);
    end
  end

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    if (clr_start) begin
      clr_busy_nxt = 1'b1;
    end else if (clr_busy_r && (clr_addr_r == LAST_ADDR)) begin
      clr_busy_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      epoch_r     <= EPOCH_FIRST;
      count_r     <= '0;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      fwd_a_en_r  <= 1'b0;
      fwd_b_en_r  <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      epoch_r     <= epoch_nxt;
      clr_busy_r  <= clr_busy_nxt;
      if (clr_start) begin
        clr_addr_r <= '0;
      end else if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (s1_fire) begin
        count_r <= res.count;
      end
      // writes landing at the same edge as the next item's reads
      if (in_fire) begin
        fwd_a_en_r <= wr_a;
        fwd_b_en_r <= wr_b;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r    <= in_item;
      s1_epoch_r   <= epoch_nxt;
      fwd_a_idx_r  <= s1_item_r.particle_a;
      fwd_b_idx_r  <= s1_item_r.particle_b;
      fwd_a_mask_r <= new_mask_a;
      fwd_b_mask_r <= new_mask_b;
      fwd_epoch_r  <= s1_epoch_r;
    end
    if (s1_fire) begin
      out_item_r.colour       <= res.colour;
      out_item_r.overflow     <= !res.found;
      out_item_r.colours_used <= res.count;
    end
  end

  // mask memories: A is written at particle_a, B at particle_b
  assign wr_a    = s1_fire && live_a && res.found;
  assign wr_b    = s1_fire && live_b && res.found;
  assign we_a    = clr_busy_r || wr_a;
  assign we_b    = clr_busy_r || wr_b;
  assign waddr_a = clr_busy_r ? clr_addr_r : AW'(s1_item_r.particle_a);
  assign waddr_b = clr_busy_r ? clr_addr_r : AW'(s1_item_r.particle_b);
  assign wdata_a = clr_busy_r ? {EPOCH_NONE, {MW{1'b0}}} : {s1_epoch_r, new_mask_a};
  assign wdata_b = clr_busy_r ? {EPOCH_NONE, {MW{1'b0}}} : {s1_epoch_r, new_mask_b};

  gcec_mask_ram #(
    .DEPTH (NUM_PARTICLES),
    .AW    (AW),
    .DW    (DW)
  ) u_ram_a (
    .clk    (clk),
    .we     (we_a),
    .waddr  (waddr_a),
    .wdata  (wdata_a),
    .re     (in_fire),
    .raddr0 (AW'(in_item.particle_a)),
    .raddr1 (AW'(in_item.particle_b)),
    .rdata0 (ra_pa),
    .rdata1 (ra_pb)
  );

  gcec_mask_ram #(
    .DEPTH (NUM_PARTICLES),
    .AW    (AW),
    .DW    (DW)
  ) u_ram_b (
    .clk    (clk),
    .we     (we_b),
    .waddr  (waddr_b),
    .wdata  (wdata_b),
    .re     (in_fire),
    .raddr0 (AW'(in_item.particle_a)),
    .raddr1 (AW'(in_item.particle_b)),
    .rdata0 (rb_pa),
    .rdata1 (rb_pb)
  );

  // mask assembly: tag check plus forwarding from the previous item
  assign live_a = !s1_item_r.a_is_static &&
                  (CMP_W'(s1_item_r.particle_a) < CMP_W'(NUM_PARTICLES));
  assign live_b = !s1_item_r.b_is_static &&
                  (CMP_W'(s1_item_r.particle_b) < CMP_W'(NUM_PARTICLES));
  assign fwd_ok = fwd_epoch_r == s1_epoch_r;

  always_comb begin
    part_a_pa = (ra_pa[DW-1:MW] == s1_epoch_r) ? ra_pa[MW-1:0] : '0;
    part_b_pa = (rb_pa[DW-1:MW] == s1_epoch_r) ? rb_pa[MW-1:0] : '0;
    part_a_pb = (ra_pb[DW-1:MW] == s1_epoch_r) ? ra_pb[MW-1:0] : '0;
    part_b_pb = (rb_pb[DW-1:MW] == s1_epoch_r) ? rb_pb[MW-1:0] : '0;
    if (fwd_ok && fwd_a_en_r && (fwd_a_idx_r == s1_item_r.particle_a)) begin
      part_a_pa = fwd_a_mask_r;
    end
    if (fwd_ok && fwd_b_en_r && (fwd_b_idx_r == s1_item_r.particle_a)) begin
      part_b_pa = fwd_b_mask_r;
    end
    if (fwd_ok && fwd_a_en_r && (fwd_a_idx_r == s1_item_r.particle_b)) begin
      part_a_pb = fwd_a_mask_r;
    end
    if (fwd_ok && fwd_b_en_r && (fwd_b_idx_r == s1_item_r.particle_b)) begin
      part_b_pb = fwd_b_mask_r;
    end
  end

  assign mask_a     = part_a_pa | part_b_pa;
  assign mask_b     = part_a_pb | part_b_pb;
  assign count_base = s1_item_r.new_frame ? '0 : count_r;

  gcec_colour_unit #(
    .MAX_COLOURS (MAX_COLOURS)
  ) u_colour (
    .mask_a     (mask_a),
    .mask_b     (mask_b),
    .live_a     (live_a),
    .live_b     (live_b),
    .count_base (count_base),
    .res        (res),
    .new_mask_a (new_mask_a),
    .new_mask_b (new_mask_b)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_item_r);

  // checks
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_tready)
    else $error("item accepted during clearing pass");

  a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !s1_valid_r)
    else $error("item in flight during clearing pass");

  a_epoch_never_none: assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r != EPOCH_NONE)
    else $error("current epoch equals the cleared tag");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.colours_used <= COUNT_W'(MAX_COLOURS)))
    else $error("colour count beyond colour limit");

endmodule

[rtl/core/gcec_mask_ram.sv]
// mask memory: one write port, two registered read ports
module gcec_mask_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 72
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output logic [DW-1:0] rdata0,
  output logic [DW-1:0] rdata1
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read returns the old word when written at the same edge
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

[rtl/core/gcec_colour_unit.sv]
// lowest free colour search, mask update and colour count
module gcec_colour_unit #(
  parameter int MAX_COLOURS = 64
) (
  input  logic [MAX_COLOURS-1:0]      mask_a,
  input  logic [MAX_COLOURS-1:0]      mask_b,
  input  logic                        live_a,
  input  logic                        live_b,
  input  logic [gcec_pkg::COUNT_W-1:0] count_base,
  output gcec_pkg::gcec_res_t          res,
  output logic [MAX_COLOURS-1:0]      new_mask_a,
  output logic [MAX_COLOURS-1:0]      new_mask_b
);
  import gcec_pkg::*;

  logic [MAX_COLOURS-1:0] taken;
  logic [MAX_COLOURS-1:0] free;
  logic [MAX_COLOURS-1:0] lowest;
  logic [COLOUR_W-1:0]    enc;
  logic [COUNT_W-1:0]     cand;
  logic                   found;

  assign taken  = (live_a ? mask_a : '0) | (live_b ? mask_b : '0);
  assign free   = ~taken;
  // isolate the lowest free colour as a one-hot bit
  assign lowest = free & (~free + MAX_COLOURS'(1));
  assign found  = |free;

  always_comb begin
    enc = '0;
    for (int c = 0; c < MAX_COLOURS; c++) begin
      if (lowest[c]) begin
        enc = enc | COLOUR_W'(c);
      end
    end
  end

  assign cand = COUNT_W'(enc) + COUNT_W'(1);

  assign new_mask_a = mask_a | lowest;
  assign new_mask_b = mask_b | lowest;

  always_comb begin
    res.found  = found;
    res.colour = found ? enc : '0;
    res.count  = (found && (cand > count_base)) ? cand : count_base;
  end

endmodule
